/* src/vpsm_pkg.sv */
`default_nettype none
package vpsm_pkg;

    localparam int CLIP_FRAMES_DEF = 65536;
    localparam int NUM_VOICES_DEF  = 9;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_PLAY  = 2'd1;
    localparam logic [1:0] REQ_WALK  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SHOT_LEN = 2'd0;
    localparam logic [1:0] CFG_LOOP_LEN = 2'd1;
    localparam logic [1:0] CFG_LOOP_EN  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               walking;
        logic               clip_select;
        logic [15:0]        sample_index;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_req;

    typedef struct packed {
        logic signed [15:0]        left_out;
        logic signed [15:0]        right_out;
        logic [NUM_VOICES_DEF-1:0] active_voices;
    } t_result;

    // signed 16-bit add with saturation
    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic signed [16:0] s;
        begin
            s = $signed({a[15], a}) + $signed({b[15], b});
            if (s > 17'sd32767) begin
                sat_add = 16'h7fff;
            end else if (s < -17'sd32768) begin
                sat_add = 16'h8000;
            end else begin
                sat_add = s[15:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

/* src/vpsm_front.sv */
`default_nettype none
module vpsm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  vpsm_pkg::t_req      i_req,
    output logic                o_q_valid,
    output vpsm_pkg::t_req      o_q_req,
    input  wire                 i_q_take
);
    import vpsm_pkg::*;

    t_req       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push_ok;

    assign full      = (r_count == 2'd2);
    assign push_ok   = push && !full;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_req   = r_slot[r_rd_ptr];

    // two-entry request queue
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_req;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_take && o_q_valid) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push_ok} - {1'b0, i_q_take && o_q_valid};
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count overflow");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> !(i_q_take && o_q_valid)) else $error("take from empty queue");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !i_q_take) |=> full) else $error("full dropped without take");
`endif

endmodule
`default_nettype wire

/* src/vpsm_back.sv */
`default_nettype none
module vpsm_back #(
    parameter int CLIP_FRAMES = vpsm_pkg::CLIP_FRAMES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  vpsm_pkg::t_req      i_q_req,
    output logic                o_q_take,
    input  wire                 i_cfg_we,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [16:0]         i_cfg_data,
    output logic                empty,
    input  wire                 pop,
    output vpsm_pkg::t_result   o_result
);
    import vpsm_pkg::*;

    localparam int NUM_VOICES = NUM_VOICES_DEF;
    localparam int AW   = $clog2(CLIP_FRAMES);
    localparam int CW   = AW + 1;
    localparam int VW   = $clog2(NUM_VOICES);
    localparam int OW   = $clog2(NUM_VOICES - 1);
    localparam int LAST = NUM_VOICES - 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PLAY  = 2'd1;
    localparam logic [1:0] ST_TICK  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    // configuration
    logic [16:0] r_shot_len, r_loop_len;
    logic        r_loop_en;
    logic [CW-1:0] shot_len_c, loop_len_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shot_len <= 17'd0;
            r_loop_len <= 17'd0;
            r_loop_en  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHOT_LEN: r_shot_len <= i_cfg_data;
                CFG_LOOP_LEN: r_loop_len <= i_cfg_data;
                CFG_LOOP_EN:  r_loop_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // length in use is capped at the store depth
    assign shot_len_c = (32'(r_shot_len) > CLIP_FRAMES) ? CW'(CLIP_FRAMES) : CW'(r_shot_len);
    assign loop_len_c = (32'(r_loop_len) > CLIP_FRAMES) ? CW'(CLIP_FRAMES) : CW'(r_loop_len);

    // voice state
    logic [NUM_VOICES-1:0] r_act, n_act;
    logic [CW-1:0]         r_cur [NUM_VOICES];
    logic [63:0]           r_order [NUM_VOICES-1];
    logic [63:0]           r_play_cnt;
    logic [1:0]            r_state, n_state;
    logic [VW-1:0]         r_idx;
    logic                  r_found;
    logic [VW-1:0]         r_pick;
    logic [63:0]           r_best;
    logic [15:0]           r_acc_l, r_acc_r, n_acc_l, n_acc_r;
    logic                  r_b_add, r_b_loop;
    logic                  r_out_valid;
    t_result               r_out;

    // voice search for a play request
    logic          p_found, p_done;
    logic [VW-1:0] p_pick;
    logic [63:0]   p_best;

    // clip memories
    logic [31:0]   shot_mem [CLIP_FRAMES];
    logic [31:0]   loop_mem [CLIP_FRAMES];
    logic [31:0]   r_shot_q, r_loop_q;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] wr_addr;

    t_req          q;
    logic          take;

    assign q       = i_q_req;
    assign take    = i_q_valid && (r_state == ST_IDLE) &&
                     ((q.req_type != REQ_TICK) || !r_out_valid);
    assign o_q_take = take;
    assign mem_we  = take && (q.req_type == REQ_WRITE) && (32'(q.sample_index) < CLIP_FRAMES);
    assign wr_addr = AW'(q.sample_index);

    always_ff @(posedge i_clk) begin
        if (mem_we && !q.clip_select) begin
            shot_mem[wr_addr] <= {q.right_sample, q.left_sample};
        end
        r_shot_q <= shot_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && q.clip_select) begin
            loop_mem[wr_addr] <= {q.right_sample, q.left_sample};
        end
        r_loop_q <= loop_mem[rd_addr];
    end

    // voice step of a tick: one voice per cycle
    logic          v_loop, v_add, v_cur_we;
    logic [CW-1:0] v_len, v_cur, v_cur1, v_cur_new;

    always_comb begin
        v_loop    = (r_idx == VW'(LAST));
        v_len     = v_loop ? loop_len_c : shot_len_c;
        v_cur     = r_cur[r_idx];
        v_cur1    = '0;
        v_add     = 1'b0;
        v_cur_we  = 1'b0;
        v_cur_new = '0;
        n_act     = r_act;
        if ((r_state == ST_TICK) && r_act[r_idx]) begin
            if (v_len == '0) begin
                n_act[r_idx] = 1'b0;
            end else if ((v_cur >= v_len) && !v_loop) begin
                n_act[r_idx] = 1'b0;
                v_cur_we     = 1'b1;
            end else begin
                if (v_cur >= v_len) begin
                    v_cur = '0;
                end
                v_add    = 1'b1;
                v_cur1   = v_cur + 1'b1;
                v_cur_we = 1'b1;
                if (!v_loop && (v_cur1 >= v_len)) begin
                    n_act[r_idx] = 1'b0;
                end else begin
                    v_cur_new = v_cur1;
                end
            end
        end
        // walking request and the voice picked by a play request
        if (take && (q.req_type == REQ_WALK) && r_loop_en && (r_loop_len != 17'd0)) begin
            n_act[LAST] = q.walking;
        end
        if ((r_state == ST_PLAY) && p_done) begin
            n_act[p_pick] = 1'b1;
        end
        rd_addr = v_cur[AW-1:0];
    end

    // accumulate the frame read for the previous voice
    always_comb begin
        logic [31:0] d;
        d       = r_b_loop ? r_loop_q : r_shot_q;
        n_acc_l = r_acc_l;
        n_acc_r = r_acc_r;
        if (r_b_add) begin
            n_acc_l = sat_add(r_acc_l, d[15:0]);
            n_acc_r = sat_add(r_acc_r, d[31:16]);
        end
    end

    // free voice first, else oldest start
    always_comb begin
        p_found = r_found;
        p_pick  = r_pick;
        p_best  = r_best;
        if (!r_act[r_idx]) begin
            p_found = 1'b1;
            p_pick  = r_idx;
        end else if ((r_idx == '0) || (r_order[r_idx[OW-1:0]] < r_best)) begin
            p_best = r_order[r_idx[OW-1:0]];
            p_pick = r_idx;
        end
        p_done = p_found || (r_idx == VW'(LAST - 1));
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take && (q.req_type == REQ_TICK)) begin
                    n_state = ST_TICK;
                end else if (take && (q.req_type == REQ_PLAY) && (r_shot_len != 17'd0)) begin
                    n_state = ST_PLAY;
                end
            end
            ST_PLAY: begin
                if (p_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (r_idx == VW'(LAST)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_b_loop <= v_loop;
        r_acc_l  <= (r_state == ST_IDLE) ? 16'd0 : n_acc_l;
        r_acc_r  <= (r_state == ST_IDLE) ? 16'd0 : n_acc_r;
        r_best   <= p_best;
        r_pick   <= p_pick;
        if (r_state == ST_DRAIN) begin
            r_out.left_out      <= n_acc_l;
            r_out.right_out     <= n_acc_r;
            r_out.active_voices <= r_act;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_act       <= '0;
            r_play_cnt  <= 64'd0;
            r_b_add     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_cur[i] <= '0;
            end
            for (int i = 0; i < NUM_VOICES - 1; i++) begin
                r_order[i] <= 64'd0;
            end
        end else begin
            r_state <= n_state;
            r_b_add <= v_add;
            r_act   <= n_act;
            r_idx   <= (n_state == r_state && r_state != ST_IDLE) ? r_idx + 1'b1 : '0;
            r_found <= 1'b0;
            if (v_cur_we) begin
                r_cur[r_idx] <= v_cur_new;
            end
            if ((r_state == ST_PLAY) && p_done) begin
                r_cur[p_pick]           <= '0;
                r_order[p_pick[OW-1:0]] <= r_play_cnt + 64'd1;
                r_play_cnt              <= r_play_cnt + 64'd1;
            end
            if (r_state == ST_DRAIN) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !r_out_valid) else $error("result register overwritten");
    a_drain_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> r_out_valid) else $error("tick gave no result");
    a_play_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PLAY) |-> (r_idx < VW'(LAST))) else $error("play scan past shot voices");
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !take) else $error("request taken while busy");
`endif

endmodule
`default_nettype wire

/* src/voice_pool_sample_mixer.sv */
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------
// request  | push / full          | i_req    (vpsm_pkg::t_req)
// result   | empty / pop          | o_result (vpsm_pkg::t_result)
// config   | cfg_valid / cfg_ready| i_cfg_index, i_cfg_data
//
// in a tick the voice sequencer visits one voice per cycle through the clip
// memory read port, then adds the last frame
// a play request runs a voice search over the shot voices, one voice a cycle;
// sample writes and walking requests are applied without leaving the idle state
// reset is synchronous and active low; clip memories are not cleared
// a two-beat request queue keeps accepting while a result waits to be popped, until it is full
`default_nettype none
module voice_pool_sample_mixer #(
    parameter int CLIP_FRAMES = vpsm_pkg::CLIP_FRAMES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  vpsm_pkg::t_req      i_req,
    output logic                empty,
    input  wire                 pop,
    output vpsm_pkg::t_result   o_result,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [16:0]         i_cfg_data
);
    import vpsm_pkg::*;

    logic q_valid, q_take;
    t_req q_req;

    assign cfg_ready = 1'b1;

    // front: request queue
    vpsm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_req   (q_req),
        .i_q_take  (q_take)
    );

    // back: voice sequencer and mixer
    vpsm_back #(
        .CLIP_FRAMES (CLIP_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_take    (q_take),
        .i_cfg_we    (cfg_valid && cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire
